### rtl/core/quaternion_to_rotation_matrix_macros.svh
// Assertion macros for the quaternion to rotation matrix block.
// Included by files that check their own logic; no other dependencies.
// Use each macro on a line of its own.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define QTRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed")
// next-cycle implication
`define QTRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed")
`else
`define QTRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define QTRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/qtrm_pkg.sv
// Package for the quaternion to rotation matrix block: widths, constants,
// pipeline stage types and the single restoring-division step.
// No dependencies.
package qtrm_pkg;

    localparam int COMP_W    = 16;   // quaternion component, Q1.15
    localparam int ELEM_W    = 16;   // matrix element, Q2.14
    localparam int NUM_ELEM  = 9;
    localparam int NORM_W    = 33;   // x^2+y^2+z^2+w^2 reaches 2^32
    localparam int PROD_W    = 32;
    localparam int SQSUM_W   = 32;   // sum of two squares reaches 2^31
    localparam int PSUM_W    = 33;   // signed sum of two products
    localparam int QUO_W     = 16;   // quotient carries one extra bit for rounding
    localparam int DIV_STEPS = QUO_W;

    localparam logic signed [ELEM_W-1:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [PROD_W-1:0] xx, yy, zz, ww;
        logic signed [PROD_W-1:0] xy, xz, yz, wx, wy, wz;
    } prod_t;

    typedef struct packed {
        logic [NORM_W-1:0]            norm;
        logic [2:0][SQSUM_W-1:0]      sq;    // yy+zz, xx+zz, xx+yy
        logic [5:0][PSUM_W-1:0]       prd;   // signed sums for off-diagonal lanes
    } sum_t;

    typedef struct packed {
        logic [NORM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic              neg;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_ELEM-1:0] lane;
        logic [NORM_W-1:0]    norm;
        logic                 zero;
    } div_t;

    // One restoring step: first step compares without shifting.
    function automatic lane_t div_step(lane_t l, logic [NORM_W-1:0] d, logic first);
        logic [NORM_W:0] trial;
        logic [NORM_W:0] diff;
        lane_t           r;
        trial = first ? {1'b0, l.rem} : {l.rem, 1'b0};
        diff  = trial - {1'b0, d};
        r     = l;
        if (trial >= {1'b0, d}) begin
            r.rem = diff[NORM_W-1:0];
            r.quo = {l.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = trial[NORM_W-1:0];
            r.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### rtl/core/quaternion_to_rotation_matrix.sv
// Quaternion (Q1.15) to normalized 3x3 rotation matrix (Q2.14), fully pipelined.
// Depends on qtrm_pkg and quaternion_to_rotation_matrix_macros.svh.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  --------+-----+--------------------------------------+------------------
//  s_      | in  | quat_x, quat_y, quat_z, quat_w       | none
//  m_      | out | m00 m01 m02 m10 m11 m12 m20 m21 m22  | zero_norm_error
//
//  One transaction per cycle in and out while m_tready holds high; stages: product,
//  sum, magnitude, 16 restoring-division stages (one quotient bit each, nine
//  lanes side by side) and the output register.
//  Reset (aresetn low, synchronous) clears only the stage valid bits.
//  Each stage holds while its successor is full and stalled, so bubbles close
//  up and input is taken while a result waits in the output register.
`include "quaternion_to_rotation_matrix_macros.svh"

module quaternion_to_rotation_matrix
    import qtrm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // m00[15:0], m01, m02, m10, m11, m12, m20, m21, m22[143:128]
    output logic         m_tuser    // zero_norm_error
);

    // stage indices
    localparam int ST_P = 0;                  // products
    localparam int ST_S = 1;                  // sums and norm
    localparam int ST_A = 2;                  // numerator magnitudes and signs
    localparam int ST_O = ST_A + DIV_STEPS + 1; // output register
    localparam int NSTG = ST_O + 1;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------
    assign en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
    generate
        for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    assign s_tready = en[ST_P];
    assign m_tvalid = v_reg[ST_O];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage P: ten 16x16 signed products straight from the input port
    // ------------------------------------------------------------------
    logic signed [COMP_W-1:0] qx, qy, qz, qw;
    prod_t prod_next, prod_reg;

    assign qx = s_tdata[15:0];
    assign qy = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];

    always_comb begin
        prod_next.xx = qx * qx;
        prod_next.yy = qy * qy;
        prod_next.zz = qz * qz;
        prod_next.ww = qw * qw;
        prod_next.xy = qx * qy;
        prod_next.xz = qx * qz;
        prod_next.yz = qy * qz;
        prod_next.wx = qw * qx;
        prod_next.wy = qw * qy;
        prod_next.wz = qw * qz;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_P]) begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // stage S: norm, diagonal square sums, off-diagonal product sums
    // ------------------------------------------------------------------
    sum_t sum_next, sum_reg;

    always_comb begin
        // squares are never negative, so zero extension is exact
        sum_next.norm   = NORM_W'(unsigned'(prod_reg.xx)) + NORM_W'(unsigned'(prod_reg.yy))
                        + NORM_W'(unsigned'(prod_reg.zz)) + NORM_W'(unsigned'(prod_reg.ww));
        sum_next.sq[0]  = unsigned'(prod_reg.yy) + unsigned'(prod_reg.zz);
        sum_next.sq[1]  = unsigned'(prod_reg.xx) + unsigned'(prod_reg.zz);
        sum_next.sq[2]  = unsigned'(prod_reg.xx) + unsigned'(prod_reg.yy);
        sum_next.prd[0] = PSUM_W'(prod_reg.xy) + PSUM_W'(prod_reg.wz);  // m01
        sum_next.prd[1] = PSUM_W'(prod_reg.xz) - PSUM_W'(prod_reg.wy);  // m02
        sum_next.prd[2] = PSUM_W'(prod_reg.xy) - PSUM_W'(prod_reg.wz);  // m10
        sum_next.prd[3] = PSUM_W'(prod_reg.yz) + PSUM_W'(prod_reg.wx);  // m12
        sum_next.prd[4] = PSUM_W'(prod_reg.xz) + PSUM_W'(prod_reg.wy);  // m20
        sum_next.prd[5] = PSUM_W'(prod_reg.yz) - PSUM_W'(prod_reg.wx);  // m21
    end

    always_ff @(posedge aclk) begin
        if (en[ST_S]) begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // stage A: dividend magnitudes. Every lane divides A by the norm to
    // get floor(A * 2^15 / n), twice the wanted Q2.14 value, and A <= n.
    //   diagonal: A = |n - 2q|        off-diagonal: A = 2|p|
    // ------------------------------------------------------------------
    function automatic lane_t diag_lane(logic [NORM_W-1:0] n, logic [SQSUM_W-1:0] q);
        logic signed [NORM_W:0] d;
        logic [NORM_W:0]        mag;
        lane_t                  l;
        d     = signed'({1'b0, n}) - signed'({1'b0, q, 1'b0});
        mag   = d[NORM_W] ? unsigned'(-d) : unsigned'(d);
        l.rem = mag[NORM_W-1:0];
        l.quo = '0;
        l.neg = d[NORM_W];
        return l;
    endfunction

    function automatic lane_t off_lane(logic signed [PSUM_W-1:0] p);
        logic [PSUM_W-1:0] mag;
        lane_t             l;
        mag   = p[PSUM_W-1] ? unsigned'(-p) : unsigned'(p);
        l.rem = {mag[PSUM_W-2:0], 1'b0};
        l.quo = '0;
        l.neg = p[PSUM_W-1];
        return l;
    endfunction

    div_t div_a_next;
    div_t div_reg [DIV_STEPS+1];   // [0] is stage A, [k+1] after division step k

    always_comb begin
        div_a_next.lane[0] = diag_lane(sum_reg.norm, sum_reg.sq[0]);
        div_a_next.lane[1] = off_lane(sum_reg.prd[0]);
        div_a_next.lane[2] = off_lane(sum_reg.prd[1]);
        div_a_next.lane[3] = off_lane(sum_reg.prd[2]);
        div_a_next.lane[4] = diag_lane(sum_reg.norm, sum_reg.sq[1]);
        div_a_next.lane[5] = off_lane(sum_reg.prd[3]);
        div_a_next.lane[6] = off_lane(sum_reg.prd[4]);
        div_a_next.lane[7] = off_lane(sum_reg.prd[5]);
        div_a_next.lane[8] = diag_lane(sum_reg.norm, sum_reg.sq[2]);
        div_a_next.norm    = sum_reg.norm;
        div_a_next.zero    = (sum_reg.norm == '0);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_A]) begin
            div_reg[0] <= div_a_next;
        end
    end

    // ------------------------------------------------------------------
    // division stages: one quotient bit per stage, MSB first.
    // A zero norm yields garbage here; the output stage overrides it.
    // ------------------------------------------------------------------
    generate
        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
            always_ff @(posedge aclk) begin
                if (en[ST_A+k+1]) begin
                    div_reg[k+1].norm <= div_reg[k].norm;
                    div_reg[k+1].zero <= div_reg[k].zero;
                    for (int l = 0; l < NUM_ELEM; l++) begin
                        div_reg[k+1].lane[l] <= div_step(div_reg[k].lane[l],
                                                         div_reg[k].norm, k == 0);
                    end
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // output stage: round half away from zero, restore sign.
    // Results stay within [-16384, 16384], so no saturation is needed.
    // ------------------------------------------------------------------
    logic [143:0] identity_data;
    logic [143:0] m_tdata_next, m_tdata_reg;
    logic         m_tuser_reg;

    always_comb begin
        identity_data = '0;
        identity_data[0*ELEM_W +: ELEM_W] = ONE_Q14;
        identity_data[4*ELEM_W +: ELEM_W] = ONE_Q14;
        identity_data[8*ELEM_W +: ELEM_W] = ONE_Q14;
    end

    always_comb begin
        logic [QUO_W:0]    up;
        logic [ELEM_W-1:0] mag;
        lane_t             l;
        m_tdata_next = '0;
        for (int e = 0; e < NUM_ELEM; e++) begin
            l   = div_reg[DIV_STEPS].lane[e];
            up  = {1'b0, l.quo} + 1'b1;
            mag = up[QUO_W:1];
            m_tdata_next[e*ELEM_W +: ELEM_W] = l.neg ? (~mag + 1'b1) : mag;
        end
        if (div_reg[DIV_STEPS].zero) begin
            m_tdata_next = identity_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_O]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= div_reg[DIV_STEPS].zero;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    logic rem_ok;
    logic elems_in_range;

    always_comb begin
        rem_ok = 1'b1;
        for (int l = 0; l < NUM_ELEM; l++) begin
            if (div_reg[DIV_STEPS].lane[l].rem >= div_reg[DIV_STEPS].norm) begin
                rem_ok = 1'b0;
            end
        end
    end

    always_comb begin
        logic signed [ELEM_W-1:0] el;
        elems_in_range = 1'b1;
        for (int e = 0; e < NUM_ELEM; e++) begin
            el = m_tdata[e*ELEM_W +: ELEM_W];
            if (el > ONE_Q14 || el < -ONE_Q14) begin
                elems_in_range = 1'b0;
            end
        end
    end

    `QTRM_ASSERT_IMPL(a_zero_identity, aclk, aresetn, m_tvalid && m_tuser, m_tdata == identity_data);
    `QTRM_ASSERT_IMPL(a_elem_range, aclk, aresetn, m_tvalid, elems_in_range);
    `QTRM_ASSERT_IMPL(a_ready_when_drained, aclk, aresetn, !m_tvalid, s_tready);
    `QTRM_ASSERT_IMPL(a_rem_bound, aclk, aresetn, v_reg[ST_O-1] && !div_reg[DIV_STEPS].zero, rem_ok);
    `QTRM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, v_reg[ST_O] && !m_tready && v_reg[ST_O-1], v_reg[ST_O-1] && $stable(div_reg[DIV_STEPS]));

endmodule

### bench/tb.sv
// Self-checking bench for quaternion_to_rotation_matrix: directed corner quaternions
// plus random traffic, with random stalls on both stream channels.
// Depends on qtrm_pkg and the block's RTL only.
module tb;
    import qtrm_pkg::*;

    localparam int  CLK_HALF      = 10;
    localparam int  RANDOM_ITEMS  = 1000;
    localparam int  HOLDOFF_LEN   = 200;      // receiver stall used to back up the pipe
    localparam int  DRAIN_CYCLES  = 40;       // extra wait after the scoreboard empties
    localparam int  TIMEOUT_CYC   = 1000000;
    // p/n is a Q0 ratio; 2p/n in Q2.14 means a left shift of 15
    localparam longint OFF_SCALE  = 64'sd32768;

    // x in the low bits, w on top, matching s_tdata
    typedef struct packed {
        logic signed [COMP_W-1:0] w;
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] x;
    } quat_t;

    typedef struct packed {
        logic                             zero_norm;
        logic [NUM_ELEM-1:0][ELEM_W-1:0]  elem;     // m00 in elem[0] .. m22 in elem[8]
    } rot_mat_t;

    // Keeps the matrices still owed by the block, in input order, and compares
    // each output transaction against the oldest one.
    class rotation_scoreboard;
        rot_mat_t expected_mats[$];
        int       mismatches;
        int       compared;
        int       zero_quats;

        function new();
            mismatches = 0;
            compared   = 0;
            zero_quats = 0;
        endfunction

        // round to nearest, ties away from zero; den is always positive here
        function longint round_div(longint num, longint den);
            bit     neg;
            longint mag;
            longint quo;
            neg = num < 0;
            mag = neg ? -num : num;
            quo = (mag * 2 + den) / (den * 2);
            return neg ? -quo : quo;
        endfunction

        function logic [ELEM_W-1:0] clamp16(longint v);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v[ELEM_W-1:0];
        endfunction

        // Rotation matrix of q with products scaled by 2/|q|^2; identity plus error flag for q = 0.
        function rot_mat_t rotation_of(quat_t q);
            longint   x, y, z, w, n;
            rot_mat_t r;
            x = q.x;
            y = q.y;
            z = q.z;
            w = q.w;
            n = x * x + y * y + z * z + w * w;
            r = '0;
            if (n == 0) begin
                r.zero_norm = 1'b1;
                r.elem[0]   = ONE_Q14;
                r.elem[4]   = ONE_Q14;
                r.elem[8]   = ONE_Q14;
                return r;
            end
            r.elem[0] = clamp16(round_div((n - 2 * (y * y + z * z)) * ONE_Q14, n));
            r.elem[1] = clamp16(round_div((x * y + w * z) * OFF_SCALE, n));
            r.elem[2] = clamp16(round_div((x * z - w * y) * OFF_SCALE, n));
            r.elem[3] = clamp16(round_div((x * y - w * z) * OFF_SCALE, n));
            r.elem[4] = clamp16(round_div((n - 2 * (x * x + z * z)) * ONE_Q14, n));
            r.elem[5] = clamp16(round_div((y * z + w * x) * OFF_SCALE, n));
            r.elem[6] = clamp16(round_div((x * z + w * y) * OFF_SCALE, n));
            r.elem[7] = clamp16(round_div((y * z - w * x) * OFF_SCALE, n));
            r.elem[8] = clamp16(round_div((n - 2 * (x * x + y * y)) * ONE_Q14, n));
            return r;
        endfunction

        function void note_quat(quat_t q);
            rot_mat_t m;
            m = rotation_of(q);
            if (m.zero_norm)
                zero_quats++;
            expected_mats.push_back(m);
        endfunction

        function void check_matrix(logic [NUM_ELEM*ELEM_W-1:0] data, logic err_flag);
            rot_mat_t          want;
            logic [ELEM_W-1:0] got;
            int                i;
            if (expected_mats.size() == 0) begin
                $error("output transaction with no quaternion outstanding");
                mismatches++;
                return;
            end
            want = expected_mats.pop_front();
            compared++;
            for (i = 0; i < NUM_ELEM; i++) begin
                got = data[i*ELEM_W +: ELEM_W];
                if (got !== want.elem[i]) begin
                    $error("m%0d%0d mismatch: expected %0d, got %0d", i / 3, i % 3,
                           $signed(want.elem[i]), $signed(got));
                    mismatches++;
                end
            end
            if (err_flag !== want.zero_norm) begin
                $error("zero_norm_error mismatch: expected %0d, got %0d",
                       want.zero_norm, err_flag);
                mismatches++;
            end
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [63:0]                  s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [NUM_ELEM*ELEM_W-1:0]   m_tdata;
    logic                         m_tuser;

    // flipped by the stimulus to ask the receiver for one long hold-off
    logic                         holdoff_req = 1'b0;
    int                           input_stall_cycles = 0;

    rotation_scoreboard sb;

    quaternion_to_rotation_matrix uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        #(longint'(TIMEOUT_CYC) * 2 * CLK_HALF);
        $display("Regression FAIL");
        $finish;
    end

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic quat_t mkq(int x, int y, int z, int w);
        quat_t q;
        q.x = x[COMP_W-1:0];
        q.y = y[COMP_W-1:0];
        q.z = z[COMP_W-1:0];
        q.w = w[COMP_W-1:0];
        return q;
    endfunction

    function automatic logic [COMP_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic quat_t random_quat();
        quat_t q;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            q = {$urandom, $urandom};
        end else if (r < 60) begin
            // tiny norms: rounding is coarsest here
            q.x = 16'($urandom_range(0, 6)) - 16'd3;
            q.y = 16'($urandom_range(0, 6)) - 16'd3;
            q.z = 16'($urandom_range(0, 6)) - 16'd3;
            q.w = 16'($urandom_range(0, 6)) - 16'd3;
        end else if (r < 80) begin
            // mixed magnitudes per component
            q.x = $signed(16'($urandom)) >>> $urandom_range(0, 15);
            q.y = $signed(16'($urandom)) >>> $urandom_range(0, 15);
            q.z = $signed(16'($urandom)) >>> $urandom_range(0, 15);
            q.w = $signed(16'($urandom)) >>> $urandom_range(0, 15);
        end else if (r < 92) begin
            // some components forced to zero (single-axis and planar rotations)
            q = {$urandom, $urandom};
            if ($urandom_range(0, 1)) q.x = '0;
            if ($urandom_range(0, 1)) q.y = '0;
            if ($urandom_range(0, 1)) q.z = '0;
            if ($urandom_range(0, 1)) q.w = '0;
        end else if (r < 97) begin
            q.x = pick_extreme();
            q.y = pick_extreme();
            q.z = pick_extreme();
            q.w = pick_extreme();
        end else begin
            q = '0;
        end
        return q;
    endfunction

    // Present one quaternion, hold it until the transaction completes, then
    // drop tvalid only if a gap follows.
    task automatic offer_quat(input quat_t q, input int gap);
        bit accepted;
        s_tdata  <= q;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
            accepted = s_tready;
            if (!accepted)
                input_stall_cycles++;
        end while (!accepted);
        sb.note_quat(q);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_mats.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: checks every completed output transaction and drives m_tready
    // with short stalls, long stalls, steady stretches and one long hold-off.
    initial begin
        int   stall_left;
        int   steady_left;
        int   hold_left;
        int   r;
        logic seen_req;
        logic ready_next;
        stall_left  = 0;
        steady_left = 0;
        hold_left   = 0;
        seen_req    = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_matrix(m_tdata, m_tuser);
            if (holdoff_req != seen_req) begin
                seen_req  = holdoff_req;
                hold_left = HOLDOFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (steady_left > 0) begin
                steady_left--;
                ready_next = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                ready_next = 1'b1;
                if (r < 10) begin
                    steady_left = $urandom_range(20, 80);
                end else if (r < 55) begin
                    steady_left = $urandom_range(0, 6);
                end else if (r < 93) begin
                    ready_next = 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else begin
                    ready_next = 1'b0;
                    stall_left = $urandom_range(10, 40);
                end
            end
            m_tready <= ready_next;
        end
    end

    initial begin
        int i;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners: zero quaternion, axis extremes, full-scale mixes,
        // smallest nonzero norms and a few known rotations
        offer_quat(mkq(0, 0, 0, 0), sender_gap());
        offer_quat(mkq(0, 0, 0, 32767), sender_gap());
        offer_quat(mkq(0, 0, 0, -32768), sender_gap());
        offer_quat(mkq(-32768, 0, 0, 0), sender_gap());
        offer_quat(mkq(0, -32768, 0, 0), sender_gap());
        offer_quat(mkq(0, 0, -32768, 0), sender_gap());
        offer_quat(mkq(32767, 0, 0, 0), sender_gap());
        offer_quat(mkq(-32768, -32768, -32768, -32768), sender_gap());
        offer_quat(mkq(32767, 32767, 32767, 32767), sender_gap());
        offer_quat(mkq(32767, -32768, 32767, -32768), sender_gap());
        offer_quat(mkq(-32768, 32767, -32768, 32767), sender_gap());
        offer_quat(mkq(1, 0, 0, 0), sender_gap());
        offer_quat(mkq(0, 0, 0, -1), sender_gap());
        offer_quat(mkq(-1, -1, -1, -1), sender_gap());
        offer_quat(mkq(1, -1, 1, -1), sender_gap());
        offer_quat(mkq(23170, 0, 0, 23170), sender_gap());
        offer_quat(mkq(0, 23170, 0, 23170), sender_gap());
        offer_quat(mkq(0, 0, 23170, -23170), sender_gap());
        offer_quat(mkq(16384, 16384, 16384, 16384), sender_gap());
        offer_quat(mkq(-16384, 16384, -16384, 16384), 0);
        offer_quat(mkq(0, 0, 0, 0), 0);
        offer_quat(mkq(12345, -23456, 7890, -3210), sender_gap());
        offer_quat(mkq(0, 1, 0, 0), sender_gap());
        offer_quat(mkq(0, 0, -1, 0), sender_gap());

        // sender waits for an empty pipe, then keeps pushing into a blocked
        // output so the pipe fills and s_tready drops
        wait_drained();
        holdoff_req <= ~holdoff_req;
        for (i = 0; i < 80; i++)
            offer_quat(random_quat(), 0);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            // every 200 items a gap-free burst
            offer_quat(random_quat(), (i % 200 < 40) ? 0 : sender_gap());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d matrices (%0d from zero quaternions); mismatches: %0d",
                 sb.compared, sb.zero_quats, sb.mismatches);
        $display("Input side saw %0d back-pressure cycles", input_stall_cycles);
        if (sb.mismatches == 0 && sb.expected_mats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/qtrm_pkg.sv
rtl/core/quaternion_to_rotation_matrix.sv
bench/tb.sv
